[rtl/rhc_pkg.sv]
`default_nettype none
package rhc_pkg;

  // Default number of output queues tracked
  localparam int QUEUES_DEFAULT = 32;

  // Header cookie
  localparam logic [23:0] COOKIE_VALUE = 24'h535345;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME_FRAC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN_V0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN_V1    = 3'd4;

  // Register reset values
  localparam logic [15:0] MIN_SIZE_RST      = 16'd6;
  localparam logic [15:0] MAX_SIZE_RST      = 16'd8972;
  localparam logic [31:0] MAX_TIME_FRAC_RST = 32'd88052499;
  localparam logic [7:0]  HDR_LEN_V0_RST    = 8'd30;
  localparam logic [7:0]  HDR_LEN_V1_RST    = 8'd32;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUF_ERR = 2'd1;
  localparam logic [1:0] ST_SIZE_ERR = 2'd2;
  localparam logic [1:0] ST_HDR_ERR = 2'd3;

  // Error kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_NOBUF   = 3'd1;
  localparam logic [2:0] KIND_SIZE    = 3'd2;
  localparam logic [2:0] KIND_PAD     = 3'd3;
  localparam logic [2:0] KIND_VERSION = 3'd4;
  localparam logic [2:0] KIND_COOKIE  = 3'd5;
  localparam logic [2:0] KIND_QUEUE   = 3'd6;
  localparam logic [2:0] KIND_TIME    = 3'd7;

  typedef struct packed {
    logic        buffer_present;
    logic [15:0] rx_size;
    logic [7:0]  pad_byte;
    logic [7:0]  format_version;
    logic [23:0] cookie;
    logic [7:0]  packet_type;
    logic [15:0] total_length;
    logic [7:0]  queue_id;
    logic [31:0] seq_number;
    logic [31:0] pulse_fraction;
    logic [31:0] prev_pulse_fraction;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  error_kind;
    logic        seq_error;
    logic        heartbeat;
    logic [7:0]  type_out;
    logic [15:0] payload_length;
  } out_item_t;

endpackage
`default_nettype wire

[rtl/rhc_ifs.sv]
`default_nettype none
// Input header channel
interface rhc_in_if;
  logic             valid;
  logic             ready;
  rhc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Verdict channel
interface rhc_out_if;
  logic              valid;
  logic              ready;
  rhc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Configuration write channel
interface rhc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rhc_pkg::CFG_IDX_W-1:0]  index;
  logic [rhc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/rhc_ram.sv]
`default_nettype none
module rhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[rtl/readout_header_checker.sv]
`default_nettype none
// Channel  Direction  Carries                          Handshake
// in_if    sink       one decoded packet header        valid/ready
// out_if   source     one verdict per header           valid/ready
// cfg_if   sink       register index and write data    valid/ready, always ready
//
// One header is taken every cycle while the verdict output is not stalled; its verdict passes
// through the read stage and then the output register before it is offered.
// The rate is set by the single read-modify-write of the sequence memory, whose
// next-sequence entry is read on accept and written back as the header leaves the read stage.
// Reset clears the per-queue valid bits at once: no clearing pass is needed.
// A stalled verdict holds in the output register while one more header
// waits in the read stage; further headers are then held off.
module readout_header_checker #(
  parameter int QUEUES = rhc_pkg::QUEUES_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rhc_in_if.sink    in_if,
  rhc_out_if.source out_if,
  rhc_cfg_if.sink   cfg_if
);

  localparam int AW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  kind;
    logic        heartbeat;
    logic [7:0]  type_out;
    logic [15:0] payload;
    logic        do_seq;
    logic [7:0]  queue_id;
    logic [31:0] seq;
  } stage_t;

  // Configuration registers
  logic [15:0] min_size_r;
  logic [15:0] max_size_r;
  logic [31:0] max_frac_r;
  logic [7:0]  hlen_v0_r;
  logic [7:0]  hlen_v1_r;

  // Pipeline registers
  logic               s1_valid_r;
  stage_t             s1_r;
  stage_t             s1_nxt;
  logic               out_valid_r;
  rhc_pkg::out_item_t out_r;
  rhc_pkg::out_item_t out_nxt;
  logic               fwd_hit_r;
  logic [31:0]        fwd_data_r;
  logic [QUEUES-1:0]  qvalid_r;

  logic        adv;
  logic        in_acc;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;
  logic [31:0] expected;
  logic [7:0]  hlen;
  logic        time_err;

  // Accept configuration writes at any time
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= rhc_pkg::MIN_SIZE_RST;
      max_size_r <= rhc_pkg::MAX_SIZE_RST;
      max_frac_r <= rhc_pkg::MAX_TIME_FRAC_RST;
      hlen_v0_r  <= rhc_pkg::HDR_LEN_V0_RST;
      hlen_v1_r  <= rhc_pkg::HDR_LEN_V1_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        rhc_pkg::REG_MIN_SIZE:      min_size_r <= cfg_if.data[15:0];
        rhc_pkg::REG_MAX_SIZE:      max_size_r <= cfg_if.data[15:0];
        rhc_pkg::REG_MAX_TIME_FRAC: max_frac_r <= cfg_if.data;
        rhc_pkg::REG_HDR_LEN_V0:    hlen_v0_r  <= cfg_if.data[7:0];
        rhc_pkg::REG_HDR_LEN_V1:    hlen_v1_r  <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: advance when the output register is free or being drained
  assign adv         = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || adv;
  assign in_acc      = in_if.valid && in_if.ready;

  // Run the header checks in priority order
  assign hlen     = in_if.data.format_version[0] ? hlen_v1_r : hlen_v0_r;
  assign time_err = (in_if.data.pulse_fraction > max_frac_r) ||
                    (in_if.data.prev_pulse_fraction > max_frac_r);

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.queue_id  = in_if.data.queue_id;
    s1_nxt.seq       = in_if.data.seq_number;
    if (!in_if.data.buffer_present || in_if.data.rx_size == 16'd0) begin
      s1_nxt.status = rhc_pkg::ST_BUF_ERR;
      s1_nxt.kind   = rhc_pkg::KIND_NOBUF;
    end else if (in_if.data.rx_size < min_size_r || in_if.data.rx_size > max_size_r) begin
      s1_nxt.status = rhc_pkg::ST_SIZE_ERR;
      s1_nxt.kind   = rhc_pkg::KIND_SIZE;
    end else if (in_if.data.pad_byte != 8'd0) begin
      s1_nxt.status = rhc_pkg::ST_HDR_ERR;
      s1_nxt.kind   = rhc_pkg::KIND_PAD;
    end else if (in_if.data.format_version > 8'd1) begin
      s1_nxt.status = rhc_pkg::ST_HDR_ERR;
      s1_nxt.kind   = rhc_pkg::KIND_VERSION;
    end else begin
      s1_nxt.type_out = in_if.data.packet_type;
      if (in_if.data.cookie != rhc_pkg::COOKIE_VALUE) begin
        s1_nxt.status = rhc_pkg::ST_HDR_ERR;
        s1_nxt.kind   = rhc_pkg::KIND_COOKIE;
      end else if (in_if.data.rx_size < {8'd0, hlen} ||
                   in_if.data.rx_size != in_if.data.total_length) begin
        s1_nxt.status = rhc_pkg::ST_SIZE_ERR;
        s1_nxt.kind   = rhc_pkg::KIND_SIZE;
      end else if ({1'b0, in_if.data.queue_id} >= 9'(QUEUES)) begin
        s1_nxt.status = rhc_pkg::ST_HDR_ERR;
        s1_nxt.kind   = rhc_pkg::KIND_QUEUE;
      end else begin
        s1_nxt.do_seq = 1'b1;
        if (time_err) begin
          s1_nxt.status = rhc_pkg::ST_HDR_ERR;
          s1_nxt.kind   = rhc_pkg::KIND_TIME;
        end else begin
          s1_nxt.status    = rhc_pkg::ST_OK;
          s1_nxt.kind      = rhc_pkg::KIND_NONE;
          s1_nxt.heartbeat = (in_if.data.total_length == {8'd0, hlen});
          s1_nxt.payload   = in_if.data.total_length - {8'd0, hlen};
        end
      end
    end
  end

  // Write back the next sequence number as the item leaves the read stage
  assign ram_we    = s1_valid_r && adv && s1_r.do_seq;
  assign ram_waddr = s1_r.queue_id[AW-1:0];
  assign ram_wdata = s1_r.seq + 32'd1;

  rhc_ram #(
    .WIDTH (32),
    .DEPTH (QUEUES)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_if.data.queue_id[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Pick forwarded, stored or reset value of the expected sequence
  always_comb begin
    if (fwd_hit_r) begin
      expected = fwd_data_r;
    end else if (qvalid_r[s1_r.queue_id[AW-1:0]]) begin
      expected = ram_rdata;
    end else begin
      expected = 32'd0;
    end
  end

  always_comb begin
    out_nxt.status         = s1_r.status;
    out_nxt.error_kind     = s1_r.kind;
    out_nxt.seq_error      = s1_r.do_seq && (expected != s1_r.seq);
    out_nxt.heartbeat      = s1_r.heartbeat;
    out_nxt.type_out       = s1_r.type_out;
    out_nxt.payload_length = s1_r.payload;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
      qvalid_r    <= '0;
    end else begin
      if (in_if.ready) begin
        s1_valid_r <= in_if.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (in_if.ready) begin
        fwd_hit_r <= in_acc && ram_we && (s1_r.queue_id == in_if.data.queue_id);
      end
      if (ram_we) begin
        qvalid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r       <= s1_nxt;
      fwd_data_r <= ram_wdata;
    end
    if (adv && s1_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Hold off input when both stages are full and the output stalls
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_if.ready |-> !in_if.ready)
    else $error("input accepted while pipeline full");

  // A written entry is marked valid
  a_qvalid_set: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> qvalid_r[$past(ram_waddr)])
    else $error("queue entry not marked valid after write");

  // Forwarding only applies to an item in the read stage
  a_fwd_stage: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r)
    else $error("forward hit without item in read stage");

  // Sequence errors only on items that passed the queue check
  a_seq_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.seq_error |->
      out_r.error_kind == rhc_pkg::KIND_NONE || out_r.error_kind == rhc_pkg::KIND_TIME)
    else $error("sequence error on rejected header");

endmodule
`default_nettype wire
